@@ rtl/esc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the environmental sensor compensation block.
package esc_pkg;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    logic [15:0] adc_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic signed [23:0] fine_temperature;
    logic [31:0]        pressure_q8;
    logic [16:0]        humidity_q10;
    logic               temp_valid;
    logic               press_valid;
    logic               hum_valid;
    logic               press_div_zero;
  } result_t;

  typedef struct packed {
    sample_t raw;
    logic    temp_valid;
    logic    press_valid;
    logic    hum_valid;
  } entry_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coef_t;

  // partial products of a 64x64 multiply, low 64 bits only
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid;
  } pp_t;

  typedef enum logic [2:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_HI  = 3'd2,
    REG_PRESS_HUM = 3'd3,
    REG_HUM       = 3'd4
  } reg_e;

  localparam logic [19:0] SKIP_20 = 20'h80000;
  localparam logic [15:0] SKIP_16 = 16'h8000;
  localparam s64_t        HUM_MAX = 64'sd419430400;
  localparam logic [16:0] HUM_Q10_MAX = 17'd102400;

  function automatic pp_t mul_parts(input s64_t a, input s64_t b);
    pp_t         r;
    logic [31:0] hl;
    logic [31:0] lh;
    r.lo  = a[31:0] * b[31:0];
    hl    = a[63:32] * b[31:0];
    lh    = a[31:0] * b[63:32];
    r.mid = hl + lh;
    return r;
  endfunction

  function automatic s64_t mul_sum(input pp_t pp);
    return s64_t'(pp.lo + {pp.mid, 32'h0});
  endfunction

  function automatic logic signed [23:0] sat24(input s64_t v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

@@ rtl/esc_front.sv @@
// Front end: accepts raw samples, flags skipped channels and queues them for the datapath.
module esc_front #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  esc_pkg::sample_t sample,
  output logic             q_valid,
  output esc_pkg::entry_t  q_item,
  input  logic             q_pop
);
  import esc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic              push;
  entry_t            classified;

  assign sample_stall = (count == CntW'(Depth));
  assign push         = sample_valid && !sample_stall;
  assign q_valid      = (count != '0);
  assign q_item       = slots[rd_ptr];

  always_comb begin
    classified.raw         = sample;
    classified.temp_valid  = (sample.adc_temperature != SKIP_20);
    classified.press_valid = (sample.adc_pressure != SKIP_20);
    classified.hum_valid   = (sample.adc_humidity != SKIP_16);
  end

  always_comb begin
    unique case ({push, q_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CntW'(Depth))
    else $error("push into full queue");
`endif

endmodule

@@ rtl/esc_back.sv @@
// Back end: pipelined compensation datapath with a bit-per-stage divider.
module esc_back (
  input  logic             clk,
  input  logic             rst,
  input  esc_pkg::coef_t   coef,
  input  logic             q_valid,
  input  esc_pkg::entry_t  q_item,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output esc_pkg::result_t result
);
  import esc_pkg::*;

  localparam int NST       = 86;
  localparam int DIV_FIRST = 15;
  localparam int DIV_LAST  = DIV_FIRST + 63;

  typedef struct packed {
    logic               tv;
    logic               pv;
    logic               hv;
    logic [19:0]        adc_t;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
    pp_t                pp0;
    pp_t                pp1;
    pp_t                pp2;
    s64_t               tv1;
    s64_t               tq;
    s64_t               tf;
    logic signed [23:0] tc;
    s64_t               pv1;
    s64_t               hx;
    s64_t               sq;
    s64_t               pk5;
    s64_t               pk2;
    s64_t               pa6;
    s64_t               pa3;
    s64_t               pv2;
    s64_t               pd;
    s64_t               nb;
    s64_t               den;
    s64_t               num;
    logic               divz;
    logic               neg;
    logic [63:0]        rem;
    logic [63:0]        quo;
    logic [63:0]        dvs;
    s64_t               q;
    s64_t               pa;
    s64_t               pb;
    s64_t               ps;
    logic [31:0]        press;
    s64_t               ha;
    s64_t               hb;
    s64_t               hc;
    s64_t               hxx;
    s64_t               hz;
    logic [16:0]        hq;
  } work_t;

  function automatic work_t step(input int k, input work_t w, input coef_t c);
    work_t       r;
    s64_t        e1;
    s64_t        dd;
    s64_t        t5;
    s64_t        hs;
    s64_t        pf;
    logic [64:0] tr;
    r = w;
    if (k >= DIV_FIRST && k <= DIV_LAST) begin
      tr = {w.rem, w.quo[63]};
      if (tr >= {1'b0, w.dvs}) begin
        tr    = tr - {1'b0, w.dvs};
        r.rem = tr[63:0];
        r.quo = {w.quo[62:0], 1'b1};
      end else begin
        r.rem = tr[63:0];
        r.quo = {w.quo[62:0], 1'b0};
      end
    end
    unique case (k)
      0: begin
        e1    = s64_t'(w.adc_t >> 3) - (s64_t'(c.t1) <<< 1);
        dd    = s64_t'(w.adc_t >> 4) - s64_t'(c.t1);
        r.pp0 = mul_parts(e1, s64_t'(c.t2));
        r.pp1 = mul_parts(dd, dd);
      end
      1: begin
        r.tv1 = mul_sum(w.pp0) >>> 11;
        r.tq  = mul_sum(w.pp1) >>> 12;
      end
      2: r.pp0 = mul_parts(w.tq, s64_t'(c.t3));
      3: r.tq = mul_sum(w.pp0) >>> 14;
      4: r.tf = s64_t'(sat24(w.tv1 + w.tq));
      5: begin
        t5    = (w.tf <<< 2) + w.tf + 64'sd128;
        r.tc  = sat24(t5 >>> 8);
        r.pv1 = w.tf - 64'sd128000;
        r.hx  = w.tf - 64'sd76800;
      end
      6: begin
        r.pp0 = mul_parts(w.pv1, w.pv1);
        r.pp1 = mul_parts(w.pv1, s64_t'(c.p5));
        r.pp2 = mul_parts(w.pv1, s64_t'(c.p2));
      end
      7: begin
        r.sq  = mul_sum(w.pp0);
        r.pk5 = mul_sum(w.pp1);
        r.pk2 = mul_sum(w.pp2);
      end
      8: begin
        r.pp0 = mul_parts(w.sq, s64_t'(c.p6));
        r.pp1 = mul_parts(w.sq, s64_t'(c.p3));
      end
      9: begin
        r.pa6 = mul_sum(w.pp0);
        r.pa3 = mul_sum(w.pp1);
      end
      10: begin
        r.pv2 = w.pa6 + (w.pk5 <<< 17) + (s64_t'(c.p4) <<< 35);
        r.pd  = (w.pa3 >>> 8) + (w.pk2 <<< 12);
      end
      11: begin
        r.pd = w.pd + (64'sd1 <<< 47);
        r.nb = ((64'sd1048576 - s64_t'(w.adc_p)) <<< 31) - w.pv2;
      end
      12: begin
        r.pp0 = mul_parts(w.pd, s64_t'(c.p1));
        r.pp1 = mul_parts(w.nb, 64'sd3125);
      end
      13: begin
        r.den = mul_sum(w.pp0) >>> 33;
        r.num = mul_sum(w.pp1);
      end
      14: begin
        r.divz = (w.den == '0);
        r.neg  = w.num[63] ^ w.den[63];
        r.rem  = '0;
        r.quo  = w.num[63] ? (~w.num + 64'sd1) : w.num;
        r.dvs  = w.den[63] ? (~w.den + 64'sd1) : w.den;
      end
      16: begin
        r.pp0 = mul_parts(s64_t'(c.h5), w.hx);
        r.pp1 = mul_parts(w.hx, s64_t'(c.h6));
        r.pp2 = mul_parts(w.hx, s64_t'(c.h3));
      end
      17: begin
        r.ha = mul_sum(w.pp0);
        r.hb = mul_sum(w.pp1);
        r.hc = mul_sum(w.pp2);
      end
      18: begin
        r.ha = (s64_t'(w.adc_h) <<< 14) - (s64_t'(c.h4) <<< 20) - w.ha;
        r.hb = w.hb >>> 10;
        r.hc = (w.hc >>> 11) + 64'sd32768;
      end
      19: begin
        r.ha  = (w.ha + 64'sd16384) >>> 15;
        r.pp0 = mul_parts(w.hb, w.hc);
      end
      20: r.hb = (mul_sum(w.pp0) >>> 10) + 64'sd2097152;
      21: r.pp0 = mul_parts(w.hb, s64_t'(c.h2));
      22: r.hb = (mul_sum(w.pp0) + 64'sd8192) >>> 14;
      23: r.pp0 = mul_parts(w.ha, w.hb);
      24: r.hxx = mul_sum(w.pp0);
      25: r.pp0 = mul_parts(w.hxx >>> 15, w.hxx >>> 15);
      26: r.hz = mul_sum(w.pp0) >>> 7;
      27: r.pp0 = mul_parts(w.hz, s64_t'(c.h1));
      28: r.hz = mul_sum(w.pp0) >>> 4;
      29: r.hxx = w.hxx - w.hz;
      30: begin
        if (w.hxx < 0) begin
          hs = '0;
        end else if (w.hxx > HUM_MAX) begin
          hs = HUM_MAX;
        end else begin
          hs = w.hxx;
        end
        r.hq = hs[28:12];
      end
      79: r.q = w.neg ? -s64_t'(w.quo) : s64_t'(w.quo);
      80: begin
        hs    = w.q >>> 13;
        r.pp0 = mul_parts(s64_t'(c.p9), hs);
        r.pp1 = mul_parts(s64_t'(c.p8), w.q);
      end
      81: begin
        r.pa = mul_sum(w.pp0);
        r.pb = mul_sum(w.pp1);
      end
      82: begin
        hs    = w.q >>> 13;
        r.pp0 = mul_parts(w.pa, hs);
        r.pb  = w.pb >>> 19;
      end
      83: r.pa = mul_sum(w.pp0) >>> 25;
      84: r.ps = w.q + w.pa + w.pb;
      85: begin
        pf      = (w.ps >>> 8) + (s64_t'(c.p7) <<< 4);
        r.press = w.divz ? 32'h0 : pf[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  work_t            st  [NST];
  work_t            nxt [NST];
  work_t            seed;
  logic [NST-1:0]   vld;
  logic             adv;

  assign adv   = !(vld[NST-1] && result_stall);
  assign q_pop = adv && q_valid;

  always_comb begin
    seed       = '0;
    seed.adc_t = q_item.raw.adc_temperature;
    seed.adc_p = q_item.raw.adc_pressure;
    seed.adc_h = q_item.raw.adc_humidity;
    seed.tv    = q_item.temp_valid;
    seed.pv    = q_item.press_valid;
    seed.hv    = q_item.hum_valid;
    nxt[0]     = step(0, seed, coef);
    for (int k = 1; k < NST; k++) begin
      nxt[k] = step(k, st[k-1], coef);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign result_valid = vld[NST-1];

  always_comb begin
    result.temperature_centi = st[NST-1].tc;
    result.fine_temperature  = st[NST-1].tf[23:0];
    result.pressure_q8       = st[NST-1].press;
    result.humidity_q10      = st[NST-1].hq;
    result.temp_valid        = st[NST-1].tv;
    result.press_valid       = st[NST-1].pv;
    result.hum_valid         = st[NST-1].hv;
    result.press_div_zero    = st[NST-1].divz;
  end

`ifndef ASSERT_OFF
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.press_div_zero |-> result.pressure_q8 == '0)
    else $error("zero divisor with nonzero pressure");
  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.humidity_q10 <= HUM_Q10_MAX)
    else $error("humidity above clamp");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> vld == $past(vld))
    else $error("pipeline moved while output stalled");
`endif

endmodule

@@ rtl/env_sensor_compensation.sv @@
// Top level of the environmental sensor compensation block: config registers and core wiring.
//
// Usage:
//   sample channel (sample_valid/sample_stall/sample) takes one raw conversion triple
//   per cycle while sample_stall is low. result channel (result_valid/result_stall/result)
//   returns temperature, fine temperature, pressure, humidity and per-channel flags.
//   Calibration words are written through the APB port at 8*index before use.
// Throughput: one item per cycle while the output is not stalled; the datapath is an
//   86-stage pipeline whose pressure division takes one quotient bit per stage.
// A four-entry queue sits in front of the pipeline; sample_stall rises only
//   when that queue is full.
// When result_stall holds on a valid result, the whole pipeline freezes and the result holds.
// Reset clears calibration registers to zero, empties the queue and drops
//   every in-flight item.
module env_sensor_compensation #(
  parameter int QueueDepth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  esc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output esc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import esc_pkg::*;

  logic [47:0]     temp_coeffs;
  logic [63:0]     press_coeffs_low;
  logic [63:0]     press_coeffs_high;
  logic [47:0]     press_last_hum_first;
  logic [31:0]     hum_coeffs_rest;
  reg_e            reg_sel;
  coef_t           coef;
  logic            q_valid;
  entry_t          q_item;
  logic            q_pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs          <= '0;
      press_coeffs_low     <= '0;
      press_coeffs_high    <= '0;
      press_last_hum_first <= '0;
      hum_coeffs_rest      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_TEMP:      temp_coeffs          <= pwdata[47:0];
        REG_PRESS_LO:  press_coeffs_low     <= pwdata;
        REG_PRESS_HI:  press_coeffs_high    <= pwdata;
        REG_PRESS_HUM: press_last_hum_first <= pwdata[47:0];
        REG_HUM:       hum_coeffs_rest      <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TEMP:      prdata = {16'h0, temp_coeffs};
      REG_PRESS_LO:  prdata = press_coeffs_low;
      REG_PRESS_HI:  prdata = press_coeffs_high;
      REG_PRESS_HUM: prdata = {16'h0, press_last_hum_first};
      REG_HUM:       prdata = {32'h0, hum_coeffs_rest};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = temp_coeffs[31:16];
    coef.t3 = temp_coeffs[47:32];
    coef.p1 = press_coeffs_low[15:0];
    coef.p2 = press_coeffs_low[31:16];
    coef.p3 = press_coeffs_low[47:32];
    coef.p4 = press_coeffs_low[63:48];
    coef.p5 = press_coeffs_high[15:0];
    coef.p6 = press_coeffs_high[31:16];
    coef.p7 = press_coeffs_high[47:32];
    coef.p8 = press_coeffs_high[63:48];
    coef.p9 = press_last_hum_first[15:0];
    coef.h1 = press_last_hum_first[23:16];
    coef.h2 = press_last_hum_first[39:24];
    coef.h3 = press_last_hum_first[47:40];
    coef.h4 = hum_coeffs_rest[11:0];
    coef.h5 = hum_coeffs_rest[23:12];
    coef.h6 = hum_coeffs_rest[31:24];
  end

  esc_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  esc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coef         (coef),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ tb/sv/env_sensor_compensation_checker.sv @@
// Checker for env_sensor_compensation: watches both channels, predicts each result and compares.
module env_sensor_compensation_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_stall,
  input  esc_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_stall,
  input  esc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  typedef logic signed [63:0] i64;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [47:0] cal_press_hum;
  logic [31:0] cal_hum;
  result_t     expected_q[$];

  function automatic i64 sx(input logic [63:0] r, input int pos, input int bits, input bit sgn);
    logic [63:0] v;
    v = (r >> pos) & ((64'd1 << bits) - 64'd1);
    if (sgn && v[bits-1]) v = v - (64'd1 << bits);
    return i64'(v);
  endfunction

  function automatic i64 clamp24(input i64 v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic result_t compensate(input sample_t s);
    result_t r;
    i64 adc_t, adc_p, adc_h, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    i64 h1, h2, h3, h4, h5, h6, v1, v2, d, tf, tc, p, x, a, b, c;
    adc_t = i64'({44'd0, s.adc_temperature});
    adc_p = i64'({44'd0, s.adc_pressure});
    adc_h = i64'({48'd0, s.adc_humidity});
    t1 = sx(cal_temp, 0, 16, 0);       t2 = sx(cal_temp, 16, 16, 1);
    t3 = sx(cal_temp, 32, 16, 1);
    p1 = sx(cal_press_lo, 0, 16, 0);   p2 = sx(cal_press_lo, 16, 16, 1);
    p3 = sx(cal_press_lo, 32, 16, 1);  p4 = sx(cal_press_lo, 48, 16, 1);
    p5 = sx(cal_press_hi, 0, 16, 1);   p6 = sx(cal_press_hi, 16, 16, 1);
    p7 = sx(cal_press_hi, 32, 16, 1);  p8 = sx(cal_press_hi, 48, 16, 1);
    p9 = sx(cal_press_hum, 0, 16, 1);  h1 = sx(cal_press_hum, 16, 8, 0);
    h2 = sx(cal_press_hum, 24, 16, 1); h3 = sx(cal_press_hum, 40, 8, 0);
    h4 = sx(cal_hum, 0, 12, 1);        h5 = sx(cal_hum, 12, 12, 1);
    h6 = sx(cal_hum, 24, 8, 1);
    r = '0;
    v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tf = clamp24(v1 + v2);
    tc = clamp24((tf * 5 + 128) >>> 8);
    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press_div_zero = 1'b1;
    end else begin
      p = 64'sd1048576 - adc_p;
      p = ((p <<< 31) - v2) * 3125;
      if (v1 == -1) p = -p;
      else p = p / v1;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      r.pressure_q8 = p[31:0];
    end
    x = tf - 76800;
    a = (adc_h <<< 14) - (h4 <<< 20) - h5 * x;
    a = (a + 16384) >>> 15;
    b = (x * h6) >>> 10;
    c = ((x * h3) >>> 11) + 32768;
    b = ((b * c) >>> 10) + 2097152;
    b = (b * h2 + 8192) >>> 14;
    x = a * b;
    x = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * h1) >>> 4);
    if (x < 0) x = 0;
    if (x > HUM_MAX) x = HUM_MAX;
    r.temperature_centi = tc[23:0];
    r.fine_temperature = tf[23:0];
    r.humidity_q10 = x[28:12];
    r.temp_valid = s.adc_temperature != SKIP_20;
    r.press_valid = s.adc_pressure != SKIP_20;
    r.hum_valid = s.adc_humidity != SKIP_16;
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cal_temp <= '0; cal_press_lo <= '0; cal_press_hi <= '0;
      cal_press_hum <= '0; cal_hum <= '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_TEMP:      cal_temp <= pwdata[47:0];
          REG_PRESS_LO:  cal_press_lo <= pwdata;
          REG_PRESS_HI:  cal_press_hi <= pwdata;
          REG_PRESS_HUM: cal_press_hum <= pwdata[47:0];
          REG_HUM:       cal_hum <= pwdata[31:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) expected_q.push_back(compensate(sample));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== result) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/env_sensor_compensation_tb.sv @@
// Top of the env_sensor_compensation testbench: clock, reset, stimulus and verdict.
module env_sensor_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  logic        clk, rst;
  logic        sample_valid, sample_stall, result_valid;
  logic        result_stall = 1'b0;
  sample_t     sample;
  result_t     result;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_idle_pct;
  int          hold_cycles = 0;
  int          hold_req = 0;
  int          hold_seen = 0;

  env_sensor_compensation u_top (.*);
  env_sensor_compensation_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("env_sensor_compensation_tb: done, errors");
    $finish;
  end

  // receiver side: random stall plus an optional long hold
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 300;
      result_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_cal(input reg_e idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain;
    sample_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic send_sample(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 0;
      @(negedge clk);
    end
    sample_valid <= 1;
    sample <= '{t, p, h};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // realistic calibration with random spread, all zeros, all ones, or fully random words
  task automatic load_cal(input int mode);
    logic [63:0] w[5];
    if (mode == 0) begin
      w[0] = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
      w[0][15:0] = 16'd27504; w[0][31:16] = 16'd26435; w[0][47:32] = 16'(-1000);
      w[1] = {16'd7000, 16'(-12000 + $urandom_range(2000)), 16'd3024, 16'd36477};
      w[2] = {16'(-15000), 16'd15500, 16'(-7), 16'(-70 + $urandom_range(140))};
      w[2] = {16'(-12000), 16'd15500, 16'(-7), 16'(140)};
      w[3] = {16'd0, 8'd0, 16'd360, 8'd75, 16'd6000};
      w[4] = {32'd0, 8'd30, 12'd50, 12'd320};
    end else if (mode == 1) begin
      for (int i = 0; i < 5; i++) w[i] = '0;
    end else if (mode == 2) begin
      for (int i = 0; i < 5; i++) w[i] = '1;
    end else begin
      for (int i = 0; i < 5; i++) w[i] = {$urandom, $urandom};
    end
    write_cal(REG_TEMP, w[0]);
    write_cal(REG_PRESS_LO, w[1]);
    write_cal(REG_PRESS_HI, w[2]);
    write_cal(REG_PRESS_HUM, w[3]);
    write_cal(REG_HUM, w[4]);
  endtask

  task automatic send_random;
    logic [19:0] t, p;
    logic [15:0] h;
    t = 20'($urandom); p = 20'($urandom); h = 16'($urandom);
    case ($urandom_range(9))
      0: t = SKIP_20;
      1: p = SKIP_20;
      2: h = SKIP_16;
      3: begin t = 20'd400000 + 20'($urandom_range(200000)); p = 20'd300000 + 20'($urandom_range(200000)); end
      default: ;
    endcase
    send_sample(t, p, h);
  endtask

  initial begin
    rst = 1; sample_valid = 0; sample = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // reset calibration: divisor is zero
    send_sample(20'd519888, 20'd415148, 16'd32000);
    drain();
    load_cal(0);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(SKIP_20, SKIP_20, SKIP_16);
    send_sample(20'd519888, 20'd415148, 16'd32000);
    send_sample(20'd400000, 20'd300000, 16'd20000);
    send_sample(20'd600000, 20'd500000, 16'd40000);
    send_sample(20'h55555, 20'hAAAAA, 16'h5555);
    send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
    drain();
    load_cal(2);
    send_sample(20'd0, 20'hFFFFF, 16'h0);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 18 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        load_cal((blk == 3) ? 3 : (blk == 2 && phase == 2) ? 1 : 0);
        if (phase == 2 && blk == 0) hold_req = hold_req + 1;
        for (int i = 0; i < 150; i++) send_random();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("env_sensor_compensation_tb: done, clean");
    end else begin
      $display("env_sensor_compensation_tb: done, errors");
    end
    $finish;
  end
endmodule
